// ===== sv/axis_angle_to_rotation_matrix_defines.svh =====
// Assertion macros for the axis-angle to rotation matrix block.
// Uses clk and rst_n of the including module; define NO_ASSERTIONS to drop them.
`ifndef AXIS_ANGLE_TO_ROTATION_MATRIX_DEFINES_SVH
`define AXIS_ANGLE_TO_ROTATION_MATRIX_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define AARM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aarm: same-cycle check failed");
`define AARM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aarm: next-cycle check failed");
`else
`define AARM_ASSERT_IMP(lbl, ante, cons)
`define AARM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== sv/aarm_pkg.sv =====
// Package for the axis-angle to rotation matrix block: beat types, CORDIC constants,
// arctangent table. No dependencies.
`default_nettype none
package aarm_pkg;

  localparam int FRAC_BITS_DEF    = 14;
  localparam int FIELD_W          = 16;
  localparam int PROD_W           = 32;
  localparam int CORDIC_W         = 34;
  localparam int CORDIC_FRAC      = 30;
  localparam int CORDIC_STAGES    = 24;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int CORDIC_PIPE      = CORDIC_STAGES / CORDIC_PER_STAGE;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INIT = 34'sd652032874;
  localparam logic signed [CORDIC_W-1:0] QUARTER_TURN     = 34'sd1073741824;
  localparam logic signed [CORDIC_W-1:0] HALF_TURN        = 34'sd2147483648;

  typedef struct packed {
    logic signed [FIELD_W-1:0] angle;
    logic signed [FIELD_W-1:0] axis_x;
    logic signed [FIELD_W-1:0] axis_y;
    logic signed [FIELD_W-1:0] axis_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] m00;
    logic signed [FIELD_W-1:0] m01;
    logic signed [FIELD_W-1:0] m02;
    logic signed [FIELD_W-1:0] m10;
    logic signed [FIELD_W-1:0] m11;
    logic signed [FIELD_W-1:0] m12;
    logic signed [FIELD_W-1:0] m20;
    logic signed [FIELD_W-1:0] m21;
    logic signed [FIELD_W-1:0] m22;
  } out_beat_t;

  function automatic logic signed [CORDIC_W-1:0] atan_turn(input int idx);
    logic signed [CORDIC_W-1:0] r;
    case (idx)
      0:       r = 34'sd536870912;
      1:       r = 34'sd316933406;
      2:       r = 34'sd167458907;
      3:       r = 34'sd85004756;
      4:       r = 34'sd42667331;
      5:       r = 34'sd21354465;
      6:       r = 34'sd10679838;
      7:       r = 34'sd5340245;
      8:       r = 34'sd2670163;
      9:       r = 34'sd1335087;
      10:      r = 34'sd667544;
      11:      r = 34'sd333772;
      12:      r = 34'sd166886;
      13:      r = 34'sd83443;
      14:      r = 34'sd41722;
      15:      r = 34'sd20861;
      16:      r = 34'sd10430;
      17:      r = 34'sd5215;
      18:      r = 34'sd2608;
      19:      r = 34'sd1304;
      20:      r = 34'sd652;
      21:      r = 34'sd326;
      22:      r = 34'sd163;
      23:      r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/axis_angle_to_rotation_matrix.sv =====
// Axis-angle to 3x3 rotation matrix, pipelined CORDIC plus multiply/round stages.
// Depends on aarm_pkg and axis_angle_to_rotation_matrix_defines.svh.
//
//   channel | ports                         | payload
//   in      | in_valid, in_ready, in_data   | aarm_pkg::in_beat_t  (angle, axis)
//   out     | out_valid, out_ready, out_data| aarm_pkg::out_beat_t (m00 .. m22)
//
// One beat per cycle while in_ready is high; a result passes through the
// ingress register, 12 CORDIC stages of two micro-rotations each, four
// multiply/round stages and the output register.
// rst_n (synchronous) clears the valid bits only; no clearing pass.
// A stalled output parks one beat in a skid register; in_ready is registered.
`default_nettype none
`include "axis_angle_to_rotation_matrix_defines.svh"
module axis_angle_to_rotation_matrix #(
  parameter int FRAC_BITS = aarm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire aarm_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output aarm_pkg::out_beat_t      out_data
);
  import aarm_pkg::*;

  localparam int CW    = FRAC_BITS + 2;
  localparam int TW    = CW + 1;
  localparam int PW    = CW + PROD_W;
  localparam int SW    = CW + FIELD_W;
  localparam int MW    = PW + 1;
  localparam int CSH   = CORDIC_FRAC - FRAC_BITS;
  localparam int NPROD = 6;
  localparam int PXX = 0, PYY = 1, PZZ = 2, PXY = 3, PYZ = 4, PZX = 5;
  localparam int SX = 0, SY = 1, SZ = 2;

  localparam logic signed [CW-1:0]       ONE   = CW'(1) << FRAC_BITS;
  localparam logic signed [CORDIC_W-1:0] CHALF = (CORDIC_W'(1) << CSH) >> 1;
  localparam logic signed [PW-1:0]       PHALF = (PW'(1) << (2 * FRAC_BITS)) >> 1;
  localparam logic signed [SW-1:0]       SHALF = (SW'(1) << FRAC_BITS) >> 1;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
  } axes_t;

  function automatic logic signed [CW-1:0] clamp_cs(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] lim;
    logic signed [CW-1:0]       r;
    lim = CORDIC_W'(ONE);
    if (v > lim) begin
      r = ONE;
    end else if (v < -lim) begin
      r = -ONE;
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] emit(input logic signed [MW-1:0] v);
    logic signed [MW-1:0] lim;
    logic signed [MW-1:0] r;
    lim = MW'(ONE);
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r[FIELD_W-1:0];
  endfunction

  logic en;

  // CORDIC pipeline, index 0 is the ingress register
  logic [CORDIC_PIPE:0]       cv_r;
  logic signed [CORDIC_W-1:0] cx_r [CORDIC_PIPE+1];
  logic signed [CORDIC_W-1:0] cy_r [CORDIC_PIPE+1];
  logic signed [CORDIC_W-1:0] cz_r [CORDIC_PIPE+1];
  logic [CORDIC_PIPE:0]       cf_r;
  axes_t                      ca_r [CORDIC_PIPE+1];

  logic signed [CORDIC_W-1:0] cx_nxt [CORDIC_PIPE];
  logic signed [CORDIC_W-1:0] cy_nxt [CORDIC_PIPE];
  logic signed [CORDIC_W-1:0] cz_nxt [CORDIC_PIPE];
  logic signed [CORDIC_W-1:0] z_in_nxt;
  logic                       flip_in_nxt;

  // post stages
  logic                       p1_valid_r, p2_valid_r, p3_valid_r, p4_valid_r;
  logic signed [CORDIC_W-1:0] p1_x_r, p1_y_r;
  logic signed [PROD_W-1:0]   p1_prod_r [NPROD];
  axes_t                      p1_ax_r;
  logic signed [CW-1:0]       p2_c_r, p2_s_r;
  logic signed [TW-1:0]       p2_t_r;
  logic signed [PROD_W-1:0]   p2_prod_r [NPROD];
  axes_t                      p2_ax_r;
  logic signed [CW-1:0]       p3_c_r;
  logic signed [PW-1:0]       p3_tp_r [NPROD];
  logic signed [SW-1:0]       p3_sa_r [3];
  logic signed [CW-1:0]       p4_c_r;
  logic signed [PW-1:0]       p4_tp_r [NPROD];
  logic signed [SW-1:0]       p4_sa_r [3];

  logic signed [CORDIC_W-1:0] x_rnd_nxt, y_rnd_nxt;
  logic signed [CW-1:0]       c_nxt;

  // output register and skid
  logic      out_valid_r, skid_valid_r;
  out_beat_t out_data_r, skid_data_r, res_nxt;

  assign en        = !skid_valid_r;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    z_in_nxt    = {{(CORDIC_W-32){in_data.angle[FIELD_W-1]}}, in_data.angle, 16'h0000};
    flip_in_nxt = 1'b0;
    if (z_in_nxt > QUARTER_TURN) begin
      z_in_nxt    = z_in_nxt - HALF_TURN;
      flip_in_nxt = 1'b1;
    end else if (z_in_nxt < -QUARTER_TURN) begin
      z_in_nxt    = z_in_nxt + HALF_TURN;
      flip_in_nxt = 1'b1;
    end
  end

  always_comb begin : cordic_step
    logic signed [CORDIC_W-1:0] xs, ys, zs, dx, dy;
    for (int g = 0; g < CORDIC_PIPE; g++) begin
      xs = cx_r[g];
      ys = cy_r[g];
      zs = cz_r[g];
      for (int k = 0; k < CORDIC_PER_STAGE; k++) begin
        dx = ys >>> (g * CORDIC_PER_STAGE + k);
        dy = xs >>> (g * CORDIC_PER_STAGE + k);
        if (zs >= 0) begin
          xs = xs - dx;
          ys = ys + dy;
          zs = zs - atan_turn(g * CORDIC_PER_STAGE + k);
        end else begin
          xs = xs + dx;
          ys = ys - dy;
          zs = zs + atan_turn(g * CORDIC_PER_STAGE + k);
        end
      end
      cx_nxt[g] = xs;
      cy_nxt[g] = ys;
      cz_nxt[g] = zs;
    end
  end

  always_comb begin
    x_rnd_nxt = (p1_x_r + CHALF) >>> CSH;
    y_rnd_nxt = (p1_y_r + CHALF) >>> CSH;
    c_nxt     = clamp_cs(x_rnd_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r       <= '0;
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
      p4_valid_r <= 1'b0;
    end else if (en) begin
      cv_r       <= {cv_r[CORDIC_PIPE-1:0], in_valid};
      p1_valid_r <= cv_r[CORDIC_PIPE];
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
      p4_valid_r <= p3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= CORDIC_GAIN_INIT;
      cy_r[0] <= '0;
      cz_r[0] <= z_in_nxt;
      cf_r[0] <= flip_in_nxt;
      ca_r[0] <= '{x: in_data.axis_x, y: in_data.axis_y, z: in_data.axis_z};
      for (int g = 0; g < CORDIC_PIPE; g++) begin
        cx_r[g+1] <= cx_nxt[g];
        cy_r[g+1] <= cy_nxt[g];
        cz_r[g+1] <= cz_nxt[g];
        cf_r[g+1] <= cf_r[g];
        ca_r[g+1] <= ca_r[g];
      end

      p1_x_r         <= cf_r[CORDIC_PIPE] ? -cx_r[CORDIC_PIPE] : cx_r[CORDIC_PIPE];
      p1_y_r         <= cf_r[CORDIC_PIPE] ? -cy_r[CORDIC_PIPE] : cy_r[CORDIC_PIPE];
      p1_ax_r        <= ca_r[CORDIC_PIPE];
      p1_prod_r[PXX] <= PROD_W'(ca_r[CORDIC_PIPE].x) * PROD_W'(ca_r[CORDIC_PIPE].x);
      p1_prod_r[PYY] <= PROD_W'(ca_r[CORDIC_PIPE].y) * PROD_W'(ca_r[CORDIC_PIPE].y);
      p1_prod_r[PZZ] <= PROD_W'(ca_r[CORDIC_PIPE].z) * PROD_W'(ca_r[CORDIC_PIPE].z);
      p1_prod_r[PXY] <= PROD_W'(ca_r[CORDIC_PIPE].x) * PROD_W'(ca_r[CORDIC_PIPE].y);
      p1_prod_r[PYZ] <= PROD_W'(ca_r[CORDIC_PIPE].y) * PROD_W'(ca_r[CORDIC_PIPE].z);
      p1_prod_r[PZX] <= PROD_W'(ca_r[CORDIC_PIPE].z) * PROD_W'(ca_r[CORDIC_PIPE].x);

      p2_c_r    <= c_nxt;
      p2_s_r    <= clamp_cs(y_rnd_nxt);
      p2_t_r    <= TW'(ONE) - TW'(c_nxt);
      p2_prod_r <= p1_prod_r;
      p2_ax_r   <= p1_ax_r;

      p3_c_r <= p2_c_r;
      for (int k = 0; k < NPROD; k++) begin
        p3_tp_r[k] <= PW'(p2_t_r) * PW'(p2_prod_r[k]);
      end
      p3_sa_r[SX] <= SW'(p2_s_r) * SW'(p2_ax_r.x);
      p3_sa_r[SY] <= SW'(p2_s_r) * SW'(p2_ax_r.y);
      p3_sa_r[SZ] <= SW'(p2_s_r) * SW'(p2_ax_r.z);

      p4_c_r <= p3_c_r;
      for (int k = 0; k < NPROD; k++) begin
        p4_tp_r[k] <= (p3_tp_r[k] + PHALF) >>> (2 * FRAC_BITS);
      end
      for (int k = 0; k < 3; k++) begin
        p4_sa_r[k] <= (p3_sa_r[k] + SHALF) >>> FRAC_BITS;
      end
    end
  end

  always_comb begin
    res_nxt.m00 = emit(MW'(p4_c_r) + MW'(p4_tp_r[PXX]));
    res_nxt.m01 = emit(MW'(p4_tp_r[PXY]) - MW'(p4_sa_r[SZ]));
    res_nxt.m02 = emit(MW'(p4_tp_r[PZX]) + MW'(p4_sa_r[SY]));
    res_nxt.m10 = emit(MW'(p4_tp_r[PXY]) + MW'(p4_sa_r[SZ]));
    res_nxt.m11 = emit(MW'(p4_c_r) + MW'(p4_tp_r[PYY]));
    res_nxt.m12 = emit(MW'(p4_tp_r[PYZ]) - MW'(p4_sa_r[SX]));
    res_nxt.m20 = emit(MW'(p4_tp_r[PZX]) - MW'(p4_sa_r[SY]));
    res_nxt.m21 = emit(MW'(p4_tp_r[PYZ]) + MW'(p4_sa_r[SX]));
    res_nxt.m22 = emit(MW'(p4_c_r) + MW'(p4_tp_r[PZZ]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= p4_valid_r;
      end
    end else if (en && p4_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_nxt;
    end
    if (en && out_valid_r && !out_ready) begin
      skid_data_r <= res_nxt;
    end
  end

  `AARM_ASSERT_IMP(a_skid_needs_out, skid_valid_r, out_valid_r)
  `AARM_ASSERT_NXT(a_stall_fills_skid, out_valid_r && !out_ready && p4_valid_r && en, skid_valid_r)
  `AARM_ASSERT_NXT(a_skid_drains, skid_valid_r && out_ready, out_valid_r && !skid_valid_r)

endmodule
`default_nettype wire
